@@ sv/source_byte_tokenizer_core_assert.svh @@
// Assertion macros for the source byte tokenizer.
`ifndef SOURCE_BYTE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_BYTE_TOKENIZER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SBT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SBT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, token kinds and character classes for the byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none
package sbt_pkg;
  localparam int unsigned MaxRunDefault    = 64;
  localparam int unsigned MaxStringDefault = 1023;
  localparam int unsigned PosWidthDefault  = 32;
  localparam int unsigned IntW = 63;
  localparam int unsigned LenW = 10;
  localparam int unsigned OutPos = 32;

  typedef enum logic [3:0] {
    K_FINISHED = 4'd0, K_ERROR = 4'd1, K_INTEGER = 4'd2, K_LABEL = 4'd3,
    K_FOR = 4'd4, K_DO = 4'd5, K_WHILE = 4'd6, K_ELSE = 4'd7, K_STRUCT = 4'd8,
    K_INT = 4'd9, K_FLOAT = 4'd10, K_STRTYPE = 4'd11, K_STRING = 4'd12,
    K_PUNCT = 4'd13, K_ADDOP = 4'd14, K_MULOP = 4'd15
  } kind_t;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001, M_INTRUN = 7'b0000010, M_LABRUN = 7'b0000100,
    M_STR = 7'b0001000, M_DROP = 7'b0010000, M_ERRSKIP = 7'b0100000,
    M_DONE = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [3:0]      kind;
    logic [IntW-1:0] int_value;
    logic [7:0]      char_value;
    logic [OutPos-1:0] start_offset;
    logic [LenW-1:0] text_length;
    logic            end_of_run;
  } token_t;

  localparam logic [IntW-1:0] IntMax = {IntW{1'b1}};

  // Word text packed one char per byte, first char lowest.
  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] i);
    logic [47:0] t;
    case (w)
      3'd0: t = {24'h0, "r", "o", "f"};
      3'd1: t = {32'h0, "o", "d"};
      3'd2: t = {8'h0, "e", "l", "i", "h", "w"};
      3'd3: t = {16'h0, "e", "s", "l", "e"};
      3'd4: t = {"t", "c", "u", "r", "t", "s"};
      3'd5: t = {24'h0, "t", "n", "i"};
      3'd6: t = {8'h0, "t", "a", "o", "l", "f"};
      default: t = {"g", "n", "i", "r", "t", "s"};
    endcase
    word_char = (i < 3'd6) ? t[i*8 +: 8] : 8'h00;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] w);
    case (w)
      3'd0: word_len = 3'd3;
      3'd1: word_len = 3'd2;
      3'd2: word_len = 3'd5;
      3'd3: word_len = 3'd4;
      3'd4: word_len = 3'd6;
      3'd5: word_len = 3'd3;
      3'd6: word_len = 3'd5;
      default: word_len = 3'd6;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    case (c)
      "{", "}", ";", ":", ",", ".", "(", ")", "[", "]", "=", "<", ">", "@",
      "#", "!", "$", "%", "^", "&", "_": is_punct = 1'b1;
      default: is_punct = 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ sv/source_byte_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core
// Streaming lexer: one source byte per item in, up to three tokens out.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                     | tuser | tlast
// s_axis  | in  | ch[7:0]                                       | -     | last
// m_axis  | out | kind[3:0] int_value[66:4] char_value[74:67]
//         |     | start_offset[106:75] text_length[116:107]      | -     | end_of_run
//
// One byte is taken per cycle, back to back, while the token queue has room:
// up to five queued tokens with no byte pending, up to two with one pending.
// The byte is registered, decoded against the scan state in one pass and its
// tokens (at most three) pushed into an 8-entry queue in the cycle after accept;
// the first token reaches m_axis through the input register and then the queue.
// Tokens drain at one per cycle while m_axis_tready is high, so only a run of
// bytes that each yield several tokens, or a stalled output, holds input off.
// Reset (rst, synchronous) empties the queue and returns the scan to idle.
// Integer accumulate is one x10 add (shift and add) per byte.
`default_nettype none
module source_byte_tokenizer_core
  import sbt_pkg::*;
#(
  parameter int unsigned MAX_RUN    = MaxRunDefault,
  parameter int unsigned MAX_STRING = MaxStringDefault,
  parameter int unsigned POS_WIDTH  = PosWidthDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // ch[7:0]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [119:0]      m_axis_tdata,   // kind, int_value, char_value, start, length
  output logic              m_axis_tlast
);
  localparam int unsigned RunMax = (MAX_STRING > MAX_RUN) ? MAX_STRING : MAX_RUN;
  localparam int unsigned RunW = $clog2(RunMax + 1);

  // input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;

  // scan state
  mode_t                mode;
  logic [IntW-1:0]      accum;
  logic [RunW-1:0]      run;
  logic [POS_WIDTH-1:0] tok_start;
  logic [POS_WIDTH-1:0] pos;
  logic [7:0]           flags;

  // output queue
  token_t     q [8];
  logic [2:0] q_rd;
  logic [3:0] q_cnt;

  mode_t                mode_next;
  logic [IntW-1:0]      accum_next;
  logic [RunW-1:0]      run_next;
  logic [POS_WIDTH-1:0] tok_start_next;
  logic [7:0]           flags_next;
  token_t               emit [3];
  logic [1:0]           n_emit;

  logic pop;
  assign pop = m_axis_tvalid && m_axis_tready;
  // accept only when the queue is certain to hold this and the pending byte
  assign s_axis_tready = (q_cnt <= (in_valid ? 4'd2 : 4'd5));

  function automatic token_t mk(input logic [3:0] k, input logic [IntW-1:0] iv,
                                input logic [7:0] cv, input logic [POS_WIDTH-1:0] st,
                                input logic [RunW-1:0] ln);
    token_t t;
    t.kind = k;
    t.int_value = iv;
    t.char_value = cv;
    t.start_offset = OutPos'(st);
    t.text_length = LenW'(ln);
    t.end_of_run = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [IntW+3:0]      prod;
    logic [3:0]           d;
    logic                 idle_path;
    logic [POS_WIDTH-1:0] p1;
    logic [3:0]           lab_kind;
    logic [7:0]           fl;
    mode_t                m;
    m = mode;
    accum_next = accum;
    run_next = run;
    tok_start_next = tok_start;
    flags_next = flags;
    fl = flags;
    n_emit = 2'd0;
    emit[0] = '0;
    emit[1] = '0;
    emit[2] = '0;
    idle_path = 1'b0;
    p1 = pos + 1'b1;
    d = in_ch[3:0];
    prod = {4'h0, accum} * 4'd10;
    prod = prod + {{IntW{1'b0}}, d};
    // label kind from current flags and run
    lab_kind = K_LABEL;
    for (int k = 7; k >= 0; k--) begin
      if (flags[k] && (run == RunW'(word_len(3'(k))))) lab_kind = 4'(K_FOR + k);
    end
    unique case (mode)
      M_INTRUN: begin
        if (is_digit(in_ch)) begin
          accum_next = (prod > {4'h0, IntMax}) ? IntMax : prod[IntW-1:0];
          run_next = run + 1'b1;
          if (run_next >= RunW'(MAX_RUN)) begin
            emit[0] = mk(K_INTEGER, accum_next, 8'h0, tok_start, run_next);
            n_emit = 2'd1;
            m = M_IDLE;
          end
        end else begin
          emit[0] = mk(K_INTEGER, accum, 8'h0, tok_start, run);
          n_emit = 2'd1;
          m = M_IDLE;
          idle_path = 1'b1;
        end
      end
      M_LABRUN: begin
        if (is_letter(in_ch)) begin
          fl = flags;
          for (int k = 0; k < 8; k++) begin
            if (!((run < RunW'(word_len(3'(k)))) &&
                  (word_char(3'(k), run[2:0]) == in_ch) && (run < RunW'(6))))
              fl[k] = 1'b0;
          end
          flags_next = fl;
          run_next = run + 1'b1;
          if (run_next >= RunW'(MAX_RUN)) begin
            lab_kind = K_LABEL;
            for (int k = 7; k >= 0; k--) begin
              if (fl[k] && (run_next == RunW'(word_len(3'(k)))))
                lab_kind = 4'(K_FOR + k);
            end
            emit[0] = mk(lab_kind, '0, 8'h0, tok_start, run_next);
            n_emit = 2'd1;
            m = M_IDLE;
          end
        end else begin
          emit[0] = mk(lab_kind, '0, 8'h0, tok_start, run);
          n_emit = 2'd1;
          m = M_IDLE;
          idle_path = 1'b1;
        end
      end
      M_STR: begin
        if (in_ch == "\"") begin
          emit[0] = mk(K_STRING, '0, 8'h0, tok_start, run);
          n_emit = 2'd1;
          m = M_IDLE;
        end else begin
          run_next = run + 1'b1;
          if (run_next >= RunW'(MAX_STRING)) begin
            emit[0] = mk(K_STRING, '0, 8'h0, tok_start, run_next);
            n_emit = 2'd1;
            m = M_DROP;
          end
        end
      end
      M_DROP: m = M_IDLE;
      M_ERRSKIP, M_DONE: m = mode;
      default: idle_path = 1'b1;
    endcase
    if (idle_path) begin
      if (in_ch == " " || in_ch == "\t" || in_ch == "\n") begin
        m = M_IDLE;
      end else if (in_ch == 8'h00) begin
        emit[n_emit] = mk(K_FINISHED, '0, 8'h0, pos, '0);
        n_emit = n_emit + 1'b1;
        m = M_DONE;
      end else if (is_digit(in_ch)) begin
        m = M_INTRUN;
        accum_next = {{(IntW-4){1'b0}}, d};
        run_next = RunW'(1);
        tok_start_next = pos;
        if (RunW'(1) >= RunW'(MAX_RUN)) m = M_IDLE;
      end else if (is_letter(in_ch)) begin
        m = M_LABRUN;
        fl = 8'h00;
        for (int k = 0; k < 8; k++) fl[k] = (word_char(3'(k), 3'd0) == in_ch);
        flags_next = fl;
        run_next = RunW'(1);
        tok_start_next = pos;
      end else if (in_ch == "\"") begin
        m = M_STR;
        run_next = '0;
        tok_start_next = p1;
      end else if (is_punct(in_ch)) begin
        emit[n_emit] = mk(K_PUNCT, '0, in_ch, pos, RunW'(1));
        n_emit = n_emit + 1'b1;
        m = M_IDLE;
      end else if (in_ch == "+" || in_ch == "-") begin
        emit[n_emit] = mk(K_ADDOP, '0, in_ch, pos, RunW'(1));
        n_emit = n_emit + 1'b1;
        m = M_IDLE;
      end else if (in_ch == "*" || in_ch == "/") begin
        emit[n_emit] = mk(K_MULOP, '0, in_ch, pos, RunW'(1));
        n_emit = n_emit + 1'b1;
        m = M_IDLE;
      end else begin
        emit[n_emit] = mk(K_ERROR, '0, in_ch, pos, RunW'(1));
        n_emit = n_emit + 1'b1;
        m = M_ERRSKIP;
      end
    end
    if (in_last) begin
      if (m == M_INTRUN) begin
        emit[n_emit] = mk(K_INTEGER, accum_next, 8'h0, tok_start_next, run_next);
        n_emit = n_emit + 1'b1;
      end else if (m == M_LABRUN) begin
        lab_kind = K_LABEL;
        for (int k = 7; k >= 0; k--) begin
          if (flags_next[k] && (run_next == RunW'(word_len(3'(k)))))
            lab_kind = 4'(K_FOR + k);
        end
        emit[n_emit] = mk(lab_kind, '0, 8'h0, tok_start_next, run_next);
        n_emit = n_emit + 1'b1;
      end else if (m == M_STR) begin
        emit[n_emit] = mk(K_STRING, '0, 8'h0, tok_start_next, run_next);
        n_emit = n_emit + 1'b1;
      end
      if (m != M_DONE) begin
        emit[n_emit] = mk(K_FINISHED, '0, 8'h0, p1, '0);
        n_emit = n_emit + 1'b1;
      end
      m = M_IDLE;
    end
    if (n_emit != 2'd0) emit[n_emit - 1'b1].end_of_run = 1'b1;
    mode_next = m;
  end

  logic [2:0] wr_base;
  assign wr_base = q_rd + q_cnt[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode <= M_IDLE;
      accum <= '0;
      run <= '0;
      tok_start <= '0;
      pos <= '0;
      flags <= 8'hFF;
      q_rd <= '0;
      q_cnt <= '0;
    end else begin
      // advance the input register
      in_valid <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        in_ch <= s_axis_tdata;
        in_last <= s_axis_tlast;
      end
      if (in_valid) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < n_emit) q[3'(wr_base + 3'(i))] <= emit[i];
        end
        if (in_last) begin
          mode <= M_IDLE;
          accum <= '0;
          run <= '0;
          tok_start <= '0;
          pos <= '0;
          flags <= 8'hFF;
        end else begin
          mode <= mode_next;
          accum <= accum_next;
          run <= run_next;
          tok_start <= tok_start_next;
          pos <= pos + 1'b1;
          flags <= flags_next;
        end
      end
      if (pop) q_rd <= q_rd + 1'b1;
      q_cnt <= q_cnt + (in_valid ? {2'b0, n_emit} : 4'd0) - {3'b0, pop};
    end
  end

  assign m_axis_tvalid = (q_cnt != 4'd0);
  assign m_axis_tdata = {3'b0, q[q_rd].text_length, q[q_rd].start_offset,
                         q[q_rd].char_value, q[q_rd].int_value, q[q_rd].kind};
  assign m_axis_tlast = q[q_rd].end_of_run;
endmodule
`default_nettype wire

@@ sv/sbt_checker.sv @@
// ----------------------------------------------------------------------------
// sbt_checker
// Port-level checks for the byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "source_byte_tokenizer_core_assert.svh"
module sbt_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [119:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);
  // a stalled token holds
  `SBT_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // no token valid directly after reset is released
  `SBT_ASSERT_NXT(a_quiet, clk, rst, $fell(rst), !m_axis_tvalid)
  // finished tokens have zero length
  `SBT_ASSERT_IMP(a_fin, clk, rst, m_axis_tvalid && m_axis_tdata[3:0] == 4'd0, m_axis_tdata[116:107] == 10'd0)
  // integer value zero on non-integer tokens
  `SBT_ASSERT_IMP(a_ival, clk, rst, m_axis_tvalid && m_axis_tdata[3:0] != 4'd2, m_axis_tdata[66:4] == 63'd0)
endmodule
bind source_byte_tokenizer_core sbt_checker u_sbt_checker (.*);
`default_nettype wire
